// ===== sv/sliding_window_outlier_detector_top_defines.svh =====
// Assertion macros for the outlier detector.
`ifndef SLIDING_WINDOW_OUTLIER_DETECTOR_TOP_DEFINES_SVH
`define SLIDING_WINDOW_OUTLIER_DETECTOR_TOP_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication.
`define SWOD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("outlier detector check failed");
// Next-cycle implication.
`define SWOD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("outlier detector check failed");
`else
`define SWOD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define SWOD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/swod_pkg.sv =====
package swod_pkg;

    localparam int MAX_HALF_WINDOW = 63;
    localparam int SAMPLE_BITS     = 24;
    localparam int INDEX_BITS      = 20;

    localparam int HALF_BITS     = 6;
    localparam int GAIN_BITS     = 12;
    localparam int CFG_DATA_BITS = 12;
    localparam int CFG_IDX_BITS  = 1;

    localparam logic [HALF_BITS-1:0] HALF_RESET = 6'd2;
    localparam logic [GAIN_BITS-1:0] GAIN_RESET = 12'd768;

    localparam int STORE_DEPTH = 2 * MAX_HALF_WINDOW + 1;
    localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
    localparam int N_BITS      = $clog2(STORE_DEPTH + 1);

    localparam int SUM_BITS    = SAMPLE_BITS + N_BITS;
    localparam int SQ_BITS     = 2 * SAMPLE_BITS + N_BITS;
    localparam int D_BITS      = SUM_BITS + 1;
    localparam int VAR_BITS    = 2 * SUM_BITS;
    localparam int VAR_LO_BITS = VAR_BITS / 2;
    localparam int VAR_HI_BITS = VAR_BITS - VAR_LO_BITS;
    localparam int K2_BITS     = 2 * GAIN_BITS;
    localparam int LHS_SHIFT   = 16;
    localparam int RHS_BITS    = VAR_BITS + K2_BITS + 1;
    localparam int LHS_BITS    = 2 * (D_BITS - 1) + LHS_SHIFT;
    localparam int CMP_BITS    = (RHS_BITS > LHS_BITS) ? RHS_BITS : LHS_BITS;

    localparam int TDATA_IN_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int TDATA_OUT_BITS = ((INDEX_BITS + 7) / 8) * 8;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_HALF_WINDOW    = 1'b0,
        CFG_THRESHOLD_GAIN = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_OLD,
        ST_RD_CTR,
        ST_UPDATE,
        ST_SUM,
        ST_TEST,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic done;
        logic outlier;
    } t_test_res;

endpackage

// ===== sv/swod_ram.sv =====
module swod_ram #(
    parameter int DEPTH     = 127,
    parameter int WIDTH     = 24,
    parameter int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [WIDTH-1:0]     i_wdata,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [WIDTH-1:0]     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/swod_test.sv =====
module swod_test (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_start,
    input  logic [swod_pkg::N_BITS-1:0]             i_win_len,
    input  logic signed [swod_pkg::SAMPLE_BITS-1:0] i_center,
    input  logic signed [swod_pkg::SUM_BITS-1:0]    i_sum,
    input  logic [swod_pkg::SQ_BITS-1:0]            i_sq,
    input  logic [swod_pkg::GAIN_BITS-1:0]          i_gain,
    output swod_pkg::t_test_res                     o_res
);

    logic [3:0] r_v;
    logic       r_done;
    logic       r_outlier;

    logic signed [swod_pkg::N_BITS:0]   n_s;
    logic [swod_pkg::SUM_BITS-1:0]      s_mag;
    logic [swod_pkg::D_BITS-2:0]        d_mag;

    // stage 0
    logic signed [swod_pkg::D_BITS-1:0]   r_nx;
    logic signed [swod_pkg::SUM_BITS-1:0] r_sum0;
    logic [swod_pkg::VAR_BITS-1:0]        r_nq;
    logic [swod_pkg::VAR_BITS-1:0]        r_ss;
    logic [swod_pkg::K2_BITS-1:0]         r_k2;
    // stage 1
    logic signed [swod_pkg::D_BITS-1:0]   r_d;
    logic [swod_pkg::VAR_BITS-1:0]        r_var;
    // stage 2
    logic                                            r_pos2;
    logic [2*(swod_pkg::D_BITS-1)-1:0]               r_dd;
    logic [swod_pkg::VAR_LO_BITS+swod_pkg::K2_BITS-1:0] r_rlo;
    logic [swod_pkg::VAR_HI_BITS+swod_pkg::K2_BITS-1:0] r_rhi;
    // stage 3
    logic                          r_pos3;
    logic [swod_pkg::CMP_BITS-1:0] r_lhs;
    logic [swod_pkg::CMP_BITS-1:0] r_rhs;

    assign n_s   = $signed({1'b0, i_win_len});
    assign s_mag = i_sum[swod_pkg::SUM_BITS-1] ? $unsigned(-i_sum) : $unsigned(i_sum);
    // d is known positive wherever the result counts
    assign d_mag = r_d[swod_pkg::D_BITS-2:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v    <= '0;
            r_done <= 1'b0;
        end else begin
            r_v    <= {r_v[2:0], i_start};
            r_done <= r_v[3];
        end
    end

    always_ff @(posedge i_clk) begin
        r_nx   <= n_s * i_center;
        r_sum0 <= i_sum;
        r_nq   <= i_win_len * i_sq;
        r_ss   <= s_mag * s_mag;
        r_k2   <= i_gain * i_gain;

        r_d   <= r_nx - swod_pkg::D_BITS'(r_sum0);
        r_var <= (r_nq >= r_ss) ? r_nq - r_ss : '0;

        r_pos2 <= (r_d > 0);
        r_dd   <= d_mag * d_mag;
        r_rlo  <= r_var[swod_pkg::VAR_LO_BITS-1:0] * r_k2;
        r_rhi  <= r_var[swod_pkg::VAR_BITS-1:swod_pkg::VAR_LO_BITS] * r_k2;

        r_pos3 <= r_pos2;
        r_lhs  <= swod_pkg::CMP_BITS'(r_dd) << swod_pkg::LHS_SHIFT;
        r_rhs  <= (swod_pkg::CMP_BITS'(r_rhi) << swod_pkg::VAR_LO_BITS)
                  + swod_pkg::CMP_BITS'(r_rlo);

        r_outlier <= r_pos3 && (r_lhs > r_rhs);
    end

    assign o_res.done    = r_done;
    assign o_res.outlier = r_outlier;

endmodule

// ===== sv/sliding_window_outlier_detector_top.sv =====
// Channel   Direction  Payload
// s_*       in         tdata: sample[23:0]; tuser: first_of_set
// m_*       out        tdata: outlier_index[19:0], zero padded to 24 bits
// cfg_*     in         idx 0: half_window[5:0], idx 1: threshold_gain[11:0]
//
// While the window fills, an item goes from accept to the next ready through four
// steps through the window memory (one read port, registered data); once the window
// is full, the variance test pipeline follows. A new sample is taken only in idle.
// Reset is synchronous; it clears the sums, pointers and state and loads the reset
// config. The window memory is never cleared; only current-set entries are read.
// A pending result waits in the output register while the next item is taken;
// only a second outlier found before the first is taken stalls the block.
`include "sliding_window_outlier_detector_top_defines.svh"

module sliding_window_outlier_detector_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    // sample
    input  logic [swod_pkg::TDATA_IN_BITS-1:0]    i_s_tdata,
    // first_of_set
    input  logic                                  i_s_tuser,
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    // outlier_index, zero padded
    output logic [swod_pkg::TDATA_OUT_BITS-1:0]   o_m_tdata,
    input  logic                                  i_cfg_wen,
    input  logic [swod_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  logic [swod_pkg::CFG_DATA_BITS-1:0]    i_cfg_wdata
);

    localparam logic [swod_pkg::INDEX_BITS-1:0] IDX_MAX = '1;
    localparam logic [swod_pkg::ADDR_BITS-1:0]  LAST_ADDR =
        swod_pkg::ADDR_BITS'(swod_pkg::STORE_DEPTH - 1);

    function automatic logic [swod_pkg::ADDR_BITS-1:0] ring_back(
        input logic [swod_pkg::ADDR_BITS-1:0] a,
        input logic [swod_pkg::N_BITS-1:0]    b
    );
        logic [swod_pkg::ADDR_BITS+1:0] t;
        t = (swod_pkg::ADDR_BITS+2)'(a) + (swod_pkg::ADDR_BITS+2)'(swod_pkg::STORE_DEPTH)
            - (swod_pkg::ADDR_BITS+2)'(b);
        if (t >= (swod_pkg::ADDR_BITS+2)'(swod_pkg::STORE_DEPTH)) begin
            t = t - (swod_pkg::ADDR_BITS+2)'(swod_pkg::STORE_DEPTH);
        end
        return swod_pkg::ADDR_BITS'(t);
    endfunction

    function automatic logic [swod_pkg::SAMPLE_BITS-1:0] mag(
        input logic signed [swod_pkg::SAMPLE_BITS-1:0] v
    );
        return v[swod_pkg::SAMPLE_BITS-1] ? $unsigned(-v) : $unsigned(v);
    endfunction

    swod_pkg::t_state r_state, n_state;

    logic [swod_pkg::HALF_BITS-1:0] r_half;
    logic [swod_pkg::GAIN_BITS-1:0] r_gain;

    logic [swod_pkg::ADDR_BITS-1:0] h_cur;
    logic [swod_pkg::N_BITS-1:0]    w_cur;

    logic signed [swod_pkg::SAMPLE_BITS-1:0] r_x;
    logic signed [swod_pkg::SAMPLE_BITS-1:0] r_old;
    logic signed [swod_pkg::SAMPLE_BITS-1:0] r_xc;
    logic [2*swod_pkg::SAMPLE_BITS-1:0]      r_xsq;
    logic [2*swod_pkg::SAMPLE_BITS-1:0]      r_osq;
    logic                                    r_evict;

    logic [swod_pkg::ADDR_BITS-1:0]       r_wp;
    logic [swod_pkg::N_BITS-1:0]          r_fill;
    logic signed [swod_pkg::SUM_BITS-1:0] r_sum;
    logic [swod_pkg::SQ_BITS-1:0]         r_sq;
    logic [swod_pkg::INDEX_BITS-1:0]      r_sc;
    logic                                 r_test_go;

    logic [swod_pkg::INDEX_BITS-1:0] r_idx;
    logic                            r_out_valid;
    logic [swod_pkg::INDEX_BITS-1:0] r_out_idx;

    logic                                 s_accept;
    logic                                 cfg_half_wr;
    logic                                 restart;
    logic [swod_pkg::N_BITS-1:0]          fill_next;
    logic [swod_pkg::INDEX_BITS-1:0]      sc_next;
    logic [swod_pkg::INDEX_BITS:0]        h_plus1;
    logic [swod_pkg::INDEX_BITS-1:0]      idx_next;
    logic                                 out_free;
    logic                                 out_load;
    logic                                 test_start;
    logic                                 ram_we;
    logic [swod_pkg::ADDR_BITS-1:0]       ram_raddr;
    logic [swod_pkg::SAMPLE_BITS-1:0]     ram_rdata;
    swod_pkg::t_test_res                  test_res;

    always_comb begin
        if (int'(r_half) > swod_pkg::MAX_HALF_WINDOW) begin
            h_cur = swod_pkg::ADDR_BITS'(swod_pkg::MAX_HALF_WINDOW);
        end else begin
            h_cur = swod_pkg::ADDR_BITS'(r_half);
        end
    end
    assign w_cur = swod_pkg::N_BITS'({h_cur, 1'b1});

    assign s_accept    = i_s_tvalid && o_s_tready;
    assign cfg_half_wr = i_cfg_wen
                         && (swod_pkg::t_cfg_idx'(i_cfg_idx) == swod_pkg::CFG_HALF_WINDOW);
    assign restart     = cfg_half_wr || (s_accept && i_s_tuser);

    assign fill_next = r_evict ? r_fill : r_fill + 1'b1;
    assign sc_next   = (r_sc < IDX_MAX) ? r_sc + 1'b1 : r_sc;
    assign h_plus1   = (swod_pkg::INDEX_BITS+1)'(h_cur) + 1'b1;
    assign idx_next  = ({1'b0, sc_next} >= h_plus1)
                       ? swod_pkg::INDEX_BITS'({1'b0, sc_next} - h_plus1) : '0;
    assign out_free  = !r_out_valid || i_m_tready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            swod_pkg::ST_IDLE: begin
                if (s_accept) begin
                    n_state = swod_pkg::ST_RD_OLD;
                end
            end
            swod_pkg::ST_RD_OLD: n_state = swod_pkg::ST_RD_CTR;
            swod_pkg::ST_RD_CTR: n_state = swod_pkg::ST_UPDATE;
            swod_pkg::ST_UPDATE: n_state = swod_pkg::ST_SUM;
            swod_pkg::ST_SUM: begin
                n_state = (fill_next == w_cur) ? swod_pkg::ST_TEST : swod_pkg::ST_IDLE;
            end
            swod_pkg::ST_TEST: begin
                if (test_res.done) begin
                    n_state = (test_res.outlier && !out_free)
                              ? swod_pkg::ST_EMIT : swod_pkg::ST_IDLE;
                end
            end
            swod_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_state = swod_pkg::ST_IDLE;
                end
            end
            default: n_state = swod_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_s_tready = 1'b0;
        test_start = 1'b0;
        out_load   = 1'b0;
        ram_we     = 1'b0;
        ram_raddr  = ring_back(r_wp, w_cur);
        unique case (r_state)
            swod_pkg::ST_IDLE:   o_s_tready = 1'b1;
            swod_pkg::ST_RD_OLD: ram_raddr  = ring_back(r_wp, w_cur);
            swod_pkg::ST_RD_CTR: ram_raddr  = ring_back(r_wp, swod_pkg::N_BITS'(h_cur));
            swod_pkg::ST_UPDATE: ram_we     = 1'b1;
            swod_pkg::ST_SUM:    ;
            swod_pkg::ST_TEST: begin
                test_start = r_test_go;
                out_load   = test_res.done && test_res.outlier && out_free;
            end
            swod_pkg::ST_EMIT:   out_load = out_free;
            default:             ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= swod_pkg::ST_IDLE;
            r_half      <= swod_pkg::HALF_RESET;
            r_gain      <= swod_pkg::GAIN_RESET;
            r_wp        <= '0;
            r_fill      <= '0;
            r_sum       <= '0;
            r_sq        <= '0;
            r_sc        <= '0;
            r_test_go   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_wen) begin
                unique case (swod_pkg::t_cfg_idx'(i_cfg_idx))
                    swod_pkg::CFG_HALF_WINDOW:
                        r_half <= i_cfg_wdata[swod_pkg::HALF_BITS-1:0];
                    swod_pkg::CFG_THRESHOLD_GAIN:
                        r_gain <= i_cfg_wdata[swod_pkg::GAIN_BITS-1:0];
                    default: ;
                endcase
            end

            if (restart) begin
                r_wp   <= '0;
                r_fill <= '0;
                r_sum  <= '0;
                r_sq   <= '0;
                r_sc   <= '0;
            end else if (r_state == swod_pkg::ST_SUM) begin
                // drop the evicted sample, add the new one
                r_sum  <= r_sum - (r_evict ? swod_pkg::SUM_BITS'(r_old) : '0)
                          + swod_pkg::SUM_BITS'(r_x);
                r_sq   <= r_sq - (r_evict ? swod_pkg::SQ_BITS'(r_osq) : '0)
                          + swod_pkg::SQ_BITS'(r_xsq);
                r_fill <= fill_next;
                r_wp   <= (r_wp == LAST_ADDR) ? '0 : r_wp + 1'b1;
                r_sc   <= sc_next;
            end

            if (r_state == swod_pkg::ST_SUM) begin
                r_test_go <= (fill_next == w_cur);
            end else if (r_state == swod_pkg::ST_TEST) begin
                r_test_go <= 1'b0;
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_x <= i_s_tdata[swod_pkg::SAMPLE_BITS-1:0];
        end
        if (r_state == swod_pkg::ST_RD_OLD) begin
            r_evict <= (r_fill >= w_cur);
            r_xsq   <= mag(r_x) * mag(r_x);
        end
        if (r_state == swod_pkg::ST_RD_CTR) begin
            r_old <= ram_rdata;
        end
        if (r_state == swod_pkg::ST_UPDATE) begin
            // with a one-sample window the centre is the new sample, not yet stored
            r_xc  <= (h_cur == '0) ? r_x : ram_rdata;
            r_osq <= mag(r_old) * mag(r_old);
        end
        if (r_state == swod_pkg::ST_SUM) begin
            r_idx <= idx_next;
        end
        if (out_load) begin
            r_out_idx <= r_idx;
        end
    end

    swod_ram #(
        .DEPTH     (swod_pkg::STORE_DEPTH),
        .WIDTH     (swod_pkg::SAMPLE_BITS),
        .ADDR_BITS (swod_pkg::ADDR_BITS)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wp),
        .i_wdata (r_x),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    swod_test u_test (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (test_start),
        .i_win_len (w_cur),
        .i_center  (r_xc),
        .i_sum     (r_sum),
        .i_sq      (r_sq),
        .i_gain    (r_gain),
        .o_res     (test_res)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = swod_pkg::TDATA_OUT_BITS'(r_out_idx);

    `SWOD_ASSERT_IMPL(fill_within_window, i_clk, i_rst_n, 1'b1, r_fill <= w_cur)
    `SWOD_ASSERT_IMPL(done_only_in_test, i_clk, i_rst_n, test_res.done, r_state == swod_pkg::ST_TEST)
    `SWOD_ASSERT_IMPL(result_from_test, i_clk, i_rst_n, $rose(o_m_tvalid), $past(r_state) == swod_pkg::ST_TEST || $past(r_state) == swod_pkg::ST_EMIT)
    `SWOD_ASSERT_NEXT(accept_starts_read, i_clk, i_rst_n, s_accept, r_state == swod_pkg::ST_RD_OLD)

endmodule

// ===== verif/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import swod_pkg::*;

    localparam int DEPTH = STORE_DEPTH;
    localparam logic [SAMPLE_BITS-1:0] S_MIN = 24'h800000;
    localparam logic [SAMPLE_BITS-1:0] S_MAX = 24'h7FFFFF;
    localparam int unsigned INDEX_MAX = (1 << INDEX_BITS) - 1;
    localparam int PLAN_LEN = 10;
    localparam int PLAN_HALF [PLAN_LEN] = '{0, 63, 63, 1, 4, 12, 2, 30, 7, 3};
    localparam int PLAN_GAIN [PLAN_LEN] = '{0, 4095, 0, 256, 400, 768, 128, 1024, 0, 2000};
    localparam int PRESSURE_PHASE = 8;
    localparam int ITEM_TARGET = 1900;
    localparam int RESULT_TARGET = 60;

    typedef enum bit [1:0] {
        ROW_SAMPLE,
        ROW_SET_HALF,
        ROW_SET_GAIN
    } row_kind_e;

    typedef enum bit [1:0] {
        EXP_MODEL,
        EXP_NONE,
        EXP_AT
    } exp_kind_e;

    typedef struct packed {
        row_kind_e              kind;
        logic [SAMPLE_BITS-1:0] value;
        bit                     fos;
        exp_kind_e              how;
        logic [INDEX_BITS-1:0]  idx;
    } step_row_t;

    localparam int ROWS = 34;
    localparam step_row_t STEP_TABLE [ROWS] = '{
        // reset setting: five-sample window never passes three sigma
        '{ROW_SAMPLE, 24'd0, 1'b1, EXP_NONE, 20'd0},
        '{ROW_SAMPLE, S_MIN, 1'b0, EXP_NONE, 20'd0},
        '{ROW_SAMPLE, S_MAX, 1'b0, EXP_NONE, 20'd0},
        '{ROW_SAMPLE, 24'd0, 1'b0, EXP_NONE, 20'd0},
        '{ROW_SAMPLE, S_MAX, 1'b0, EXP_NONE, 20'd0},
        '{ROW_SAMPLE, S_MIN, 1'b0, EXP_NONE, 20'd0},
        // zero gain: any center above the mean is flagged
        '{ROW_SET_GAIN, 24'd0, 1'b0, EXP_NONE, 20'd0},
        '{ROW_SET_HALF, 24'd1, 1'b0, EXP_NONE, 20'd0},
        // no first flag: the write restarted the set
        '{ROW_SAMPLE, 24'd5, 1'b0, EXP_NONE, 20'd0},
        '{ROW_SAMPLE, 24'd5, 1'b0, EXP_NONE, 20'd0},
        '{ROW_SAMPLE, 24'd5, 1'b0, EXP_NONE, 20'd0},
        '{ROW_SAMPLE, 24'd100, 1'b0, EXP_NONE, 20'd0},
        '{ROW_SAMPLE, 24'd5, 1'b0, EXP_AT, 20'd3},
        // set too short for the window
        '{ROW_SAMPLE, 24'd7, 1'b1, EXP_NONE, 20'd0},
        '{ROW_SAMPLE, 24'd8, 1'b0, EXP_NONE, 20'd0},
        '{ROW_SAMPLE, 24'hFFFFFF, 1'b1, EXP_NONE, 20'd0},
        '{ROW_SAMPLE, 24'hFFFFFF, 1'b0, EXP_NONE, 20'd0},
        '{ROW_SAMPLE, S_MIN, 1'b0, EXP_AT, 20'd1},
        '{ROW_SAMPLE, S_MAX, 1'b0, EXP_MODEL, 20'd0},
        '{ROW_SAMPLE, 24'd3, 1'b0, EXP_MODEL, 20'd0},
        // single-sample window: center always equals the mean
        '{ROW_SET_HALF, 24'd0, 1'b0, EXP_NONE, 20'd0},
        '{ROW_SAMPLE, S_MAX, 1'b1, EXP_NONE, 20'd0},
        '{ROW_SAMPLE, S_MIN, 1'b0, EXP_NONE, 20'd0},
        '{ROW_SET_GAIN, 24'd4095, 1'b0, EXP_NONE, 20'd0},
        '{ROW_SAMPLE, S_MAX, 1'b0, EXP_NONE, 20'd0},
        '{ROW_SET_GAIN, 24'd256, 1'b0, EXP_NONE, 20'd0},
        '{ROW_SET_HALF, 24'd2, 1'b0, EXP_NONE, 20'd0},
        '{ROW_SAMPLE, 24'd0, 1'b1, EXP_MODEL, 20'd0},
        '{ROW_SAMPLE, 24'd0, 1'b0, EXP_MODEL, 20'd0},
        '{ROW_SAMPLE, 24'd1000, 1'b0, EXP_MODEL, 20'd0},
        '{ROW_SAMPLE, 24'd0, 1'b0, EXP_MODEL, 20'd0},
        '{ROW_SAMPLE, 24'd0, 1'b0, EXP_MODEL, 20'd0},
        '{ROW_SAMPLE, 24'd0, 1'b0, EXP_MODEL, 20'd0},
        '{ROW_SAMPLE, S_MIN, 1'b0, EXP_MODEL, 20'd0}
    };

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_s_tvalid = 1'b0;
    logic                      o_s_tready;
    logic [TDATA_IN_BITS-1:0]  i_s_tdata = '0;
    logic                      i_s_tuser = 1'b0;
    logic                      o_m_tvalid;
    logic                      i_m_tready = 1'b0;
    logic [TDATA_OUT_BITS-1:0] o_m_tdata;
    logic                      i_cfg_wen = 1'b0;
    logic [CFG_IDX_BITS-1:0]   i_cfg_idx = '0;
    logic [CFG_DATA_BITS-1:0]  i_cfg_wdata = '0;

    // predictor state
    logic signed [SAMPLE_BITS-1:0] win_mem [DEPTH];
    int unsigned    win_wr;
    int unsigned    win_fill;
    longint         win_sum;
    longint unsigned win_sq;
    int unsigned    set_pos;
    int unsigned    cur_half;
    int unsigned    cur_gain;

    logic [INDEX_BITS-1:0] pending_index [$];
    logic [INDEX_BITS-1:0] due_index;
    int mismatches = 0;
    int items_sent = 0;
    int results_seen = 0;
    int tx_idle_max = 13;
    int rx_idle_max = 13;
    int rx_gap = 0;
    int hold_left = 0;
    int hold_req_len = 0;
    bit hold_req = 1'b0;

    sliding_window_outlier_detector_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic void flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: mismatch: %s", $realtime, what);
        end
    endfunction

    function automatic void restart_set();
        win_wr = 0;
        win_fill = 0;
        win_sum = 0;
        win_sq = 0;
        set_pos = 0;
    endfunction

    // Returns 1 when the center sample of the updated window is an outlier.
    function automatic bit judge_center(input logic [SAMPLE_BITS-1:0] value, input bit fos,
                                        output logic [INDEX_BITS-1:0] idx);
        int unsigned n;
        longint x;
        longint old;
        longint xc;
        longint dev;
        longint sum_mag;
        bit [127:0] dv;
        bit [127:0] lhs;
        bit [127:0] nq;
        bit [127:0] s2;
        bit [127:0] spread;
        bit [127:0] rhs;
        n = 2 * cur_half + 1;
        idx = '0;
        if (fos) begin
            restart_set();
        end
        x = longint'($signed(value));
        if (win_fill >= n) begin
            old = longint'(win_mem[(win_wr + DEPTH - n) % DEPTH]);
            win_sum -= old;
            win_sq -= longint'(old * old);
        end else begin
            win_fill++;
        end
        win_mem[win_wr] = value;
        win_wr = (win_wr + 1) % DEPTH;
        win_sum += x;
        win_sq += longint'(x * x);
        if (set_pos < INDEX_MAX) begin
            set_pos++;
        end
        if (win_fill != n) begin
            return 1'b0;
        end
        xc = longint'(win_mem[(win_wr + DEPTH - 1 - cur_half) % DEPTH]);
        dev = longint'(n) * xc - win_sum;
        if (dev <= 0) begin
            return 1'b0;
        end
        dv = 128'(dev);
        lhs = (dv * dv) << 16;
        nq = 128'(n) * 128'(win_sq);
        sum_mag = (win_sum < 0) ? -win_sum : win_sum;
        s2 = 128'(sum_mag) * 128'(sum_mag);
        spread = (s2 > nq) ? 128'd0 : nq - s2;
        rhs = spread * (128'(cur_gain) * 128'(cur_gain));
        if (lhs > rhs) begin
            idx = (set_pos >= cur_half + 1) ? INDEX_BITS'(set_pos - 1 - cur_half) : '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic write_reg(input t_cfg_idx sel, input int value);
        i_cfg_wen <= 1'b1;
        i_cfg_idx <= sel;
        i_cfg_wdata <= CFG_DATA_BITS'(value);
        @(posedge i_clk);
        i_cfg_wen <= 1'b0;
        if (sel == CFG_HALF_WINDOW) begin
            cur_half = value & 6'h3F;
            restart_set();
        end else begin
            cur_gain = value & 12'hFFF;
        end
        @(posedge i_clk);
    endtask

    task automatic push_sample(input logic [SAMPLE_BITS-1:0] value, input bit fos,
                               input exp_kind_e how, input logic [INDEX_BITS-1:0] typed);
        int gap;
        bit hit;
        logic [INDEX_BITS-1:0] idx;
        gap = (tx_idle_max == 0) ? 0 : $urandom_range(0, tx_idle_max);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= value;
        i_s_tuser <= fos;
        do @(posedge i_clk); while (!o_s_tready);
        items_sent++;
        hit = judge_center(value, fos, idx);
        case (how)
            EXP_MODEL: if (hit) pending_index.push_back(idx);
            EXP_AT:    pending_index.push_back(typed);
            default:   ;
        endcase
    endtask

    // Drop valid, let outstanding results drain, then let the pipeline go quiet.
    task automatic settle();
        int waited;
        waited = 0;
        i_s_tvalid <= 1'b0;
        while (pending_index.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (40) @(posedge i_clk);
        if (pending_index.size() != 0) begin
            flag_mismatch($sformatf("%0d expected outliers never arrived",
                                    pending_index.size()));
            pending_index.delete();
        end
    endtask

    // Result side: check, then draw the next stall.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                results_seen++;
                if (pending_index.size() == 0) begin
                    flag_mismatch($sformatf("unexpected outlier index %0d", o_m_tdata));
                end else begin
                    due_index = pending_index.pop_front();
                    if (o_m_tdata !== TDATA_OUT_BITS'(due_index)) begin
                        flag_mismatch($sformatf("outlier index expected %0d, got %0d",
                                                due_index, o_m_tdata));
                    end
                end
                rx_gap = (rx_idle_max == 0) ? 0 : $urandom_range(0, rx_idle_max);
            end
            if (hold_req) begin
                hold_left = hold_req_len;
                hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    initial begin
        #2_400_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        int phase;
        int half;
        int gain;
        int budget;
        int sent;
        int set_len;
        int style;
        int base;
        int amp;
        int v;
        bit fos;
        bit first_set;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        cur_half = HALF_RESET;
        cur_gain = GAIN_RESET;
        restart_set();

        foreach (STEP_TABLE[r]) begin
            case (STEP_TABLE[r].kind)
                ROW_SET_HALF: begin
                    settle();
                    write_reg(CFG_HALF_WINDOW, int'(STEP_TABLE[r].value));
                end
                ROW_SET_GAIN: begin
                    settle();
                    write_reg(CFG_THRESHOLD_GAIN, int'(STEP_TABLE[r].value));
                end
                default: push_sample(STEP_TABLE[r].value, STEP_TABLE[r].fos,
                                     STEP_TABLE[r].how, STEP_TABLE[r].idx);
            endcase
        end

        phase = 0;
        while ((items_sent < ITEM_TARGET || results_seen < RESULT_TARGET) && phase < 24) begin
            settle();
            if (phase < PLAN_LEN) begin
                half = PLAN_HALF[phase];
                gain = PLAN_GAIN[phase];
            end else begin
                half = $urandom_range(0, 12);
                gain = $urandom_range(0, 700);
            end
            write_reg(CFG_THRESHOLD_GAIN, gain);
            write_reg(CFG_HALF_WINDOW, half);
            tx_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 13;
            rx_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 13;
            if (phase == PRESSURE_PHASE) begin
                // hold the result side off long enough to back up the input
                tx_idle_max = 0;
                hold_req_len = 600;
                hold_req = 1'b1;
            end
            budget = (half > 20) ? 320 : 150;
            sent = 0;
            first_set = 1'b1;
            while (sent < budget) begin
                if ($urandom_range(0, 9) == 0) begin
                    set_len = $urandom_range(1, 2 * half + 1);
                end else begin
                    set_len = 2 * half + 1 + $urandom_range(0, 6 * half + 40);
                end
                style = $urandom_range(0, 9);
                base = int'($urandom_range(0, 32'hFFFFFF)) - 8388608;
                amp = 1 << $urandom_range(0, 16);
                for (int i = 0; i < set_len; i++) begin
                    case (style)
                        0: v = base;
                        1: v = int'($urandom_range(0, 32'hFFFFFF)) - 8388608;
                        2: begin
                            case ($urandom_range(0, 2))
                                0: v = -8388608;
                                1: v = 8388607;
                                default: v = 0;
                            endcase
                        end
                        default: begin
                            v = base + int'($urandom_range(0, amp)) - amp / 2;
                            if ($urandom_range(0, 11) == 0) begin
                                if ($urandom_range(0, 1) == 1) begin
                                    v += int'($urandom_range(0, 8388607));
                                end else begin
                                    v -= int'($urandom_range(0, 8388607));
                                end
                            end
                        end
                    endcase
                    if (v > 8388607) v = 8388607;
                    if (v < -8388608) v = -8388608;
                    fos = (i == 0) && (!first_set || $urandom_range(0, 1) == 1);
                    push_sample(SAMPLE_BITS'(v), fos, EXP_MODEL, '0);
                    sent++;
                end
                first_set = 1'b0;
            end
            phase++;
        end

        settle();
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
